// File: hw/rtl/utf8v_pkg.sv
package utf8v_pkg;

    // Lead and boundary byte values used by the sequence checks.
    localparam logic [7:0] C_LEAD_C0     = 8'hC0;
    localparam logic [7:0] C_LEAD_C1     = 8'hC1;
    localparam logic [7:0] C_LEAD_E0     = 8'hE0;
    localparam logic [7:0] C_LEAD_ED     = 8'hED;
    localparam logic [7:0] C_LEAD_F0     = 8'hF0;
    localparam logic [7:0] C_LEAD_F4     = 8'hF4;
    localparam logic [7:0] C_ASCII_LIMIT = 8'h80;
    localparam logic [7:0] C_SEC_8F      = 8'h8F;
    localparam logic [7:0] C_SEC_90      = 8'h90;
    localparam logic [7:0] C_SEC_9F      = 8'h9F;
    localparam logic [7:0] C_SEC_A0      = 8'hA0;

    localparam logic C_STATUS_OK  = 1'b0;
    localparam logic C_STATUS_BAD = 1'b1;

    // Outcome of one byte applied to the collector.
    typedef struct packed {
        logic            emit;
        logic            status;
        logic [31:0]     seq_bytes;
        logic [2:0]      seq_len;
        logic [2:0][7:0] held;
        logic [2:0]      exp_len;
        logic [2:0]      count;
    } t_step;

endpackage

// File: hw/rtl/utf8_sequence_validator.sv
// UTF-8 sequence validator. Raw bytes enter one beat at a time on the input
// channel; each ASCII byte, each finished multi-byte sequence and each
// sequence broken by a non-ASCII byte leaves as one result beat carrying a
// status (0 valid glyph, 1 invalid), the collected bytes packed low byte
// first with unused bytes zero, and the byte count. Bytes that only extend
// a sequence, and a partial sequence cut off by an ASCII byte, produce no
// beat. Throughput is one byte per cycle unless stalled: a byte is
// registered, checked against the collector in a single short
// combinational pass, and written to the result register. The input register
// keeps taking bytes while a result waits; the input stalls only when a byte
// that produces a result finds the result register still full and stalled.
module utf8_sequence_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic [31:0] o_seq_bytes,
    output logic [2:0]  o_seq_len
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Collector state.
    logic [2:0][7:0] r_held;
    logic [2:0]      r_exp_len;
    logic [2:0]      r_count;

    // Result register.
    logic        r_out_valid;
    logic        r_status;
    logic [31:0] r_seq_bytes;
    logic [2:0]  r_seq_len;

    utf8v_pkg::t_step step;
    logic             out_free;
    logic             s1_go;

    utf8v_step u_step (
        .i_byte    (r_in_byte),
        .i_held    (r_held),
        .i_exp_len (r_exp_len),
        .i_count   (r_count),
        .o_step    (step)
    );

    // The held byte may move on when it makes no result or the result
    // register is empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_go    = r_in_valid && (!step.emit || out_free);
    assign o_stall  = r_in_valid && !s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Collector state is cleared by reset because an idle collector must
    // hold zeros for the packing of the next sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_exp_len <= 3'd0;
            r_count   <= 3'd0;
        end else if (s1_go) begin
            r_held    <= step.held;
            r_exp_len <= step.exp_len;
            r_count   <= step.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && step.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_go && step.emit) begin
            r_status    <= step.status;
            r_seq_bytes <= step.seq_bytes;
            r_seq_len   <= step.seq_len;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_seq_bytes = r_seq_bytes;
    assign o_seq_len   = r_seq_len;

    // An idle collector holds nothing.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len == 3'd0) |-> (r_count == 3'd0 && r_held == '0))
        else $error("idle collector holds bytes");

    // A sequence in progress holds at least the lead and is not yet complete.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp_len != 3'd0) |-> (r_count >= 3'd1 && r_count < r_exp_len))
        else $error("held count out of range for expected length");

    // A result carries one to four bytes.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_seq_len >= 3'd1 && o_seq_len <= 3'd4))
        else $error("result length out of range");

    // Bytes beyond a one-byte result are zero.
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_seq_len == 3'd1) |-> (o_seq_bytes[31:8] == 24'h0))
        else $error("unused result bytes not zero");

    // A held byte that makes no result never stalls the input.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step.emit) |-> !o_stall)
        else $error("input stalled without a pending result");

endmodule

// File: hw/rtl/utf8v_step.sv
module utf8v_step (
    input  logic [7:0]       i_byte,
    input  logic [2:0][7:0]  i_held,
    input  logic [2:0]       i_exp_len,
    input  logic [2:0]       i_count,
    output utf8v_pkg::t_step o_step
);

    logic        is_cont;
    logic        is_full;
    logic        bad_end;
    logic [7:0]  second;
    logic [31:0] packed_bytes;

    always_comb begin
        is_cont = (i_byte[7:6] == 2'b10);
        is_full = (({1'b0, i_count} + 4'd1) >= {1'b0, i_exp_len}) || (i_count >= 3'd3);
        second  = (i_count >= 3'd2) ? i_held[1] : i_byte;

        bad_end = ((i_held[0] == utf8v_pkg::C_LEAD_F4) && (second > utf8v_pkg::C_SEC_8F))
               || ((i_held[0] == utf8v_pkg::C_LEAD_F0) && (second < utf8v_pkg::C_SEC_90))
               || ((i_held[0] == utf8v_pkg::C_LEAD_ED) && (second > utf8v_pkg::C_SEC_9F))
               || ((i_held[0] == utf8v_pkg::C_LEAD_E0) && (second < utf8v_pkg::C_SEC_A0));

        // The new byte lands right after the bytes already held.
        case (i_count)
            3'd0:    packed_bytes = {24'h0, i_byte};
            3'd1:    packed_bytes = {16'h0, i_byte, i_held[0]};
            3'd2:    packed_bytes = {8'h0, i_byte, i_held[1], i_held[0]};
            default: packed_bytes = {i_byte, i_held[2], i_held[1], i_held[0]};
        endcase
    end

    always_comb begin
        o_step           = '0;
        o_step.held      = i_held;
        o_step.exp_len   = i_exp_len;
        o_step.count     = i_count;
        o_step.seq_len   = (i_count >= 3'd3) ? 3'd4 : (i_count + 3'd1);
        o_step.seq_bytes = packed_bytes;

        if (i_byte < utf8v_pkg::C_ASCII_LIMIT) begin
            // ASCII drops any partial sequence and passes as one glyph.
            o_step.emit      = 1'b1;
            o_step.status    = utf8v_pkg::C_STATUS_OK;
            o_step.seq_bytes = {24'h0, i_byte};
            o_step.seq_len   = 3'd1;
            o_step.held      = '0;
            o_step.exp_len   = 3'd0;
            o_step.count     = 3'd0;
        end else if (i_exp_len == 3'd0) begin
            o_step.seq_bytes = {24'h0, i_byte};
            o_step.seq_len   = 3'd1;
            if ((i_byte == utf8v_pkg::C_LEAD_C0) || (i_byte == utf8v_pkg::C_LEAD_C1)
                || (i_byte > utf8v_pkg::C_LEAD_F4) || is_cont) begin
                o_step.emit   = 1'b1;
                o_step.status = utf8v_pkg::C_STATUS_BAD;
                o_step.held   = '0;
                o_step.count  = 3'd0;
            end else begin
                o_step.held[0] = i_byte;
                o_step.count   = 3'd1;
                if (i_byte[7:5] == 3'b110) begin
                    o_step.exp_len = 3'd2;
                end else if (i_byte[7:4] == 4'b1110) begin
                    o_step.exp_len = 3'd3;
                end else begin
                    o_step.exp_len = 3'd4;
                end
            end
        end else if (!is_cont || is_full) begin
            o_step.emit    = 1'b1;
            o_step.status  = (!is_cont || bad_end) ? utf8v_pkg::C_STATUS_BAD
                                                   : utf8v_pkg::C_STATUS_OK;
            o_step.held    = '0;
            o_step.exp_len = 3'd0;
            o_step.count   = 3'd0;
        end else begin
            o_step.held[i_count[1:0]] = i_byte;
            o_step.count              = i_count + 3'd1;
        end
    end

endmodule
